/* hw/rtl/tbp_pkg.sv */
// Shared types, constants and hash step for the per-flow token bucket policer.
package tbp_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 4096;
  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned CFG_AW = 4;
  localparam int unsigned KEY_W = 32;
  localparam int unsigned TIME_W = 48;
  localparam int unsigned CREDIT_W = 36;
  localparam int unsigned RATE_W = 20;
  localparam int unsigned BURST_W = 16;

  localparam logic [31:0] FNV_BASIS = 32'h811C_9DC5;
  localparam logic [31:0] FNV_PRIME = 32'h0100_0193;

  localparam logic [RATE_W-1:0] MICRO = 20'd1000000;
  localparam logic [RATE_W-1:0] RATE_RST = 20'd100;
  localparam logic [BURST_W-1:0] BURST_RST = 16'd200;

  localparam int unsigned DIV_SH = 6;
  localparam logic [13:0] DIV_LO = 14'd15625;
  localparam int unsigned RECIP_SH = 44;
  localparam logic [30:0] RECIP_LO = 31'((64'd1 << RECIP_SH) / 64'd15625);

  typedef enum logic [1:0] {
    REG_ENABLE = 2'd0,
    REG_RATE   = 2'd1,
    REG_BURST  = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic                enable;
    logic [RATE_W-1:0]   rate;
    logic [BURST_W-1:0]  burst;
  } cfg_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [TIME_W-1:0] now;
  } item_t;

  function automatic logic [31:0] fnv_step(input logic [31:0] h, input logic [7:0] b);
    logic [31:0] x;
    x = h ^ {24'b0, b};
    return x * FNV_PRIME;
  endfunction

endpackage

/* hw/rtl/tbp_front.sv */
// Front pipeline: accepts requests, hashes the key and reduces it to a table slot.
module tbp_front
  import tbp_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              accept_i,
  input  logic [KEY_W-1:0]                  key_i,
  input  logic [TIME_W-1:0]                 now_i,
  input  logic                              full_i,
  output logic                              stall_o,
  output logic                              push_o,
  output item_t                             item_o,
  output logic [$clog2(TABLE_ENTRIES)-1:0]  idx_o
);

  localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
  localparam int unsigned NSTG = 7;
  localparam int unsigned SHIFT = 32 + IDX_W;
  localparam logic [32:0] RECIP = 33'((65'd1 << SHIFT) / 65'(TABLE_ENTRIES));
  localparam logic [31:0] ENT32 = 32'(TABLE_ENTRIES);

  logic [NSTG-1:0]  vld_r;
  item_t            itm_r [NSTG];
  logic [31:0]      hash_r [5];
  logic [31:0]      qe_r;
  logic [31:0]      rem_r;
  logic [IDX_W-1:0] idx_r;
  logic             adv;
  logic [64:0]      prod;

  assign adv = !(vld_r[NSTG-1] && full_i);
  assign prod = {33'b0, hash_r[3]} * {32'b0, RECIP};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NSTG-2:0], accept_i};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      itm_r[0] <= '{key: key_i, now: now_i};
      for (int k = 1; k < NSTG; k++) begin
        itm_r[k] <= itm_r[k-1];
      end
      hash_r[0] <= fnv_step(FNV_BASIS, key_i[31:24]);
      for (int k = 1; k < 4; k++) begin
        hash_r[k] <= fnv_step(hash_r[k-1], itm_r[k-1].key[31-8*k -: 8]);
      end
      hash_r[4] <= hash_r[3];
      qe_r <= 32'(prod >> SHIFT);
      rem_r <= hash_r[4] - qe_r * ENT32;
      idx_r <= IDX_W'((rem_r >= ENT32) ? rem_r - ENT32 : rem_r);
    end
  end

  assign stall_o = !adv;
  assign push_o = vld_r[NSTG-1] && !full_i;
  assign item_o = itm_r[NSTG-1];
  assign idx_o = idx_r;

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> vld_r[NSTG-1])
    else $error("front output stage lost an item while stalled");

  a_slot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[NSTG-1] |-> 32'(idx_r) < ENT32)
    else $error("slot index beyond table");

endmodule

/* hw/rtl/tbp_fifo.sv */
// Short queue that decouples the hashing front from the table back end.
module tbp_fifo
  import tbp_pkg::*;
#(
  parameter int unsigned W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  input  logic         pop_i,
  output logic [W-1:0] data_o,
  output logic         full_o,
  output logic         empty_o
);

  localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

  logic [W-1:0]     buf_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wptr_r, wptr_nxt;
  logic [PTR_W-1:0] rptr_r, rptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full_o = cnt_r == CNT_W'(FIFO_DEPTH);
  assign empty_o = cnt_r == '0;
  assign data_o = buf_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt = cnt_r;
    if (push_i) begin
      wptr_nxt = (wptr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (pop_i) begin
      rptr_nxt = (rptr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      buf_r[wptr_r] <= data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push_i |-> (!full_o || pop_i))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop_i |-> !empty_o)
    else $error("queue read while empty");

endmodule

/* hw/rtl/tbp_back.sv */
// Back end: clears the slot table, then runs refill, spend and token count per enabled request.
module tbp_back
  import tbp_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  cfg_t                              cfg_i,
  input  logic                              empty_i,
  input  item_t                             item_i,
  input  logic [$clog2(TABLE_ENTRIES)-1:0]  idx_i,
  output logic                              pop_o,
  output logic                              clearing_o,
  output logic                              out_valid_o,
  output logic                              out_allowed_o,
  output logic                              out_new_entry_o,
  output logic [BURST_W-1:0]                out_tokens_o
);

  localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);

  typedef struct packed {
    logic                valid;
    logic [KEY_W-1:0]    key;
    logic [CREDIT_W-1:0] credit;
    logic [TIME_W-1:0]   last;
  } slot_t;

  typedef enum logic [7:0] {
    ST_CLEAR = 8'b0000_0001,
    ST_IDLE  = 8'b0000_0010,
    ST_LOAD  = 8'b0000_0100,
    ST_MUL   = 8'b0000_1000,
    ST_CLAMP = 8'b0001_0000,
    ST_SPEND = 8'b0010_0000,
    ST_DIV1  = 8'b0100_0000,
    ST_DIV2  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic [IDX_W-1:0] clr_cnt_r, clr_cnt_nxt;

  slot_t mem_r [TABLE_ENTRIES];
  slot_t rd_r;
  slot_t wdata;
  logic [IDX_W-1:0] waddr;
  logic we;

  logic [KEY_W-1:0]    key_r;
  logic [TIME_W-1:0]   now_r;
  logic [IDX_W-1:0]    idx_r;
  logic [CREDIT_W-1:0] cap_r;
  logic                fresh_r;
  logic [CREDIT_W-1:0] credit_r;
  logic [CREDIT_W-1:0] elapsed_r;
  logic                sat_r;
  logic [55:0]         add_r;
  logic [CREDIT_W-1:0] clamp_r;
  logic                pass_r;
  logic [29:0]         x_r;
  logic [60:0]         prod_r;

  logic                out_valid_r, out_valid_nxt;
  logic                out_allowed_r;
  logic                out_new_r;
  logic [BURST_W-1:0]  out_tok_r;

  logic                fresh;
  logic [TIME_W-1:0]   last;
  logic [TIME_W-1:0]   elapsed;
  logic [56:0]         sum;
  logic                pass;
  logic [CREDIT_W-1:0] newc;
  logic [16:0]         qe;
  logic [30:0]         rem;
  logic [16:0]         quo;

  assign fresh = !rd_r.valid || (rd_r.key != key_r);
  assign last = fresh ? now_r : rd_r.last;
  assign elapsed = (now_r > last) ? now_r - last : '0;
  assign sum = 57'(credit_r) + 57'(add_r);
  assign pass = clamp_r >= CREDIT_W'(MICRO);
  assign newc = pass ? clamp_r - CREDIT_W'(MICRO) : clamp_r;
  assign qe = prod_r[60:RECIP_SH];
  assign rem = {1'b0, x_r} - 31'({14'b0, qe} * {17'b0, DIV_LO});
  assign quo = (rem >= 31'(DIV_LO)) ? qe + 1'b1 : qe;

  assign pop_o = (state_r == ST_IDLE) && !empty_i;
  assign we = (state_r == ST_CLEAR) || (state_r == ST_SPEND);
  assign waddr = (state_r == ST_CLEAR) ? clr_cnt_r : idx_r;
  assign wdata = (state_r == ST_CLEAR) ? '0 :
                 '{valid: 1'b1, key: key_r, credit: newc, last: now_r};

  always_comb begin
    state_nxt = state_r;
    clr_cnt_nxt = clr_cnt_r;
    out_valid_nxt = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == IDX_W'(TABLE_ENTRIES - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (!empty_i) begin
          if (cfg_i.enable) begin
            state_nxt = ST_LOAD;
          end else begin
            out_valid_nxt = 1'b1;
          end
        end
      end
      ST_LOAD:  state_nxt = ST_MUL;
      ST_MUL:   state_nxt = ST_CLAMP;
      ST_CLAMP: state_nxt = ST_SPEND;
      ST_SPEND: state_nxt = ST_DIV1;
      ST_DIV1:  state_nxt = ST_DIV2;
      ST_DIV2: begin
        state_nxt = ST_IDLE;
        out_valid_nxt = 1'b1;
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rd_r <= mem_r[idx_i];
  end

  always_ff @(posedge clk) begin
    cap_r <= CREDIT_W'(cfg_i.burst) * CREDIT_W'(MICRO);
    if (pop_o) begin
      key_r <= item_i.key;
      now_r <= item_i.now;
      idx_r <= idx_i;
      out_allowed_r <= 1'b1;
      out_new_r <= 1'b0;
      out_tok_r <= '0;
    end
    if (state_r == ST_LOAD) begin
      fresh_r <= fresh;
      credit_r <= fresh ? cap_r : rd_r.credit;
      elapsed_r <= elapsed[CREDIT_W-1:0];
      sat_r <= elapsed >= TIME_W'(cap_r);
    end
    if (state_r == ST_MUL) begin
      if (cfg_i.rate == '0) begin
        add_r <= '0;
      end else if (sat_r) begin
        add_r <= 56'(cap_r);
      end else begin
        add_r <= 56'(elapsed_r) * 56'(cfg_i.rate);
      end
    end
    if (state_r == ST_CLAMP) begin
      clamp_r <= (sum > 57'(cap_r)) ? cap_r : sum[CREDIT_W-1:0];
    end
    if (state_r == ST_SPEND) begin
      pass_r <= pass;
      x_r <= newc[CREDIT_W-1:DIV_SH];
    end
    if (state_r == ST_DIV1) begin
      prod_r <= {31'b0, x_r} * {30'b0, RECIP_LO};
    end
    if (state_r == ST_DIV2) begin
      out_allowed_r <= pass_r;
      out_new_r <= fresh_r;
      out_tok_r <= quo[BURST_W-1:0];
    end
  end

  assign clearing_o = state_r == ST_CLEAR;
  assign out_valid_o = out_valid_r;
  assign out_allowed_o = out_allowed_r;
  assign out_new_entry_o = out_new_r;
  assign out_tokens_o = out_tok_r;

  a_clamp_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SPEND) |-> (clamp_r <= cap_r))
    else $error("credit above bucket capacity");

  a_tokens_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_tok_r <= cfg_i.burst))
    else $error("tokens left above burst size");

  a_clear_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |=> (state_r == ST_CLEAR || state_r == ST_IDLE))
    else $error("clearing pass left to a working state");

endmodule

/* hw/rtl/per_flow_token_bucket_policer.sv */
// Top level of the per-flow token bucket policer with its configuration registers.
// An enabled request passes the front pipeline, the queue and the back-end states LOAD,
// MUL, CLAMP, SPEND, DIV1 and DIV2 before its result is registered; a disabled request
// skips those states. The back-end table sequencer takes a new enabled request only after
// the last is done; disabled requests pass at one per cycle while busy is low. The
// receiver cannot stall results. After reset the slot table is cleared with busy held high.
module per_flow_token_bucket_policer
  import tbp_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [KEY_W-1:0]    in_source_key,
  input  logic [TIME_W-1:0]   in_now_us,
  output logic                out_valid,
  output logic                out_allowed,
  output logic                out_new_entry,
  output logic [BURST_W-1:0]  out_tokens_left,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CFG_AW-1:0]   paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
  localparam int unsigned QW = $bits(item_t) + IDX_W;

  cfg_t cfg_r;
  logic cfg_we;
  reg_idx_t reg_sel;

  logic accept;
  logic stall;
  logic clearing;
  logic push;
  item_t f_item;
  logic [IDX_W-1:0] f_idx;
  logic [QW-1:0] q_out;
  logic q_full;
  logic q_empty;
  logic pop;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;
  assign reg_sel = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{enable: 1'b1, rate: RATE_RST, burst: BURST_RST};
    end else if (cfg_we) begin
      case (reg_sel)
        REG_ENABLE: cfg_r.enable <= pwdata[0];
        REG_RATE:   cfg_r.rate <= pwdata[RATE_W-1:0];
        REG_BURST:  cfg_r.burst <= pwdata[BURST_W-1:0];
        default:    cfg_r <= cfg_r;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_ENABLE: prdata = {31'b0, cfg_r.enable};
      REG_RATE:   prdata = {12'b0, cfg_r.rate};
      REG_BURST:  prdata = {16'b0, cfg_r.burst};
      default:    prdata = '0;
    endcase
  end

  assign busy = stall || clearing;
  assign accept = start && !busy;

  tbp_front #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept_i (accept),
    .key_i    (in_source_key),
    .now_i    (in_now_us),
    .full_i   (q_full),
    .stall_o  (stall),
    .push_o   (push),
    .item_o   (f_item),
    .idx_o    (f_idx)
  );

  tbp_fifo #(
    .W(QW)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (push),
    .data_i  ({f_idx, f_item}),
    .pop_i   (pop),
    .data_o  (q_out),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  tbp_back #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_i           (cfg_r),
    .empty_i         (q_empty),
    .item_i          (item_t'(q_out[$bits(item_t)-1:0])),
    .idx_i           (q_out[QW-1:$bits(item_t)]),
    .pop_o           (pop),
    .clearing_o      (clearing),
    .out_valid_o     (out_valid),
    .out_allowed_o   (out_allowed),
    .out_new_entry_o (out_new_entry),
    .out_tokens_o    (out_tokens_left)
  );

endmodule
